>>> hdl/data_directive_syntax_check_assert.svh
// Assertion macros for the checker file of the data-directive checker.
// No dependencies; the using module must provide i_clk and i_rst_n.
`ifndef DATA_DIRECTIVE_SYNTAX_CHECK_ASSERT_SVH
`define DATA_DIRECTIVE_SYNTAX_CHECK_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define DDSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ddsc checker: assertion failed");

// Next-cycle implication, disabled while reset is held
`define DDSC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ddsc checker: assertion failed");

`endif

>>> hdl/ddsc_pkg.sv
// Package for the data-directive syntax checker: line state type, phase codes,
// character constants and the per-character update. No dependencies.
package ddsc_pkg;

    // Scan phases
    localparam logic [2:0] PH_LEAD = 3'd0;
    localparam logic [2:0] PH_KEY  = 3'd1;
    localparam logic [2:0] PH_SEP  = 3'd2;
    localparam logic [2:0] PH_SCAN = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    localparam logic [2:0] KW_LEN = 3'd5;

    // Characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_T  = 8'h74;

    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] prefix_pos;
        logic       lead_seen;
        logic       after_comma;
        logic       digit_seen;
        logic       gap_seen;
        logic       leading_zero;
        logic       number_start;
        logic       sign_pending;
        logic       rejected;
    } t_line_state;

    localparam t_line_state LINE_RST = '{
        phase:        PH_LEAD,
        prefix_pos:   3'd0,
        lead_seen:    1'b0,
        after_comma:  1'b0,
        digit_seen:   1'b0,
        gap_seen:     1'b0,
        leading_zero: 1'b0,
        number_start: 1'b1,
        sign_pending: 1'b0,
        rejected:     1'b0
    };

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Expected character of ".data" at a given position
    function automatic logic [7:0] keyword_char(logic [2:0] pos);
        logic [7:0] k;
        case (pos)
            3'd0:    k = CH_DOT;
            3'd1:    k = CH_LC_D;
            3'd2:    k = CH_LC_A;
            3'd3:    k = CH_LC_T;
            3'd4:    k = CH_LC_A;
            default: k = 8'h00;
        endcase
        return k;
    endfunction

    // Number-list rules for one character
    function automatic t_line_state scan_char(t_line_state s_in, logic [7:0] c);
        t_line_state s;
        logic        dig;
        logic        sgn;
        logic        comma;
        s     = s_in;
        dig   = is_digit(c);
        sgn   = (c == CH_PLUS) || (c == CH_MINUS);
        comma = (c == CH_COMMA);
        // a sign must be followed by a digit
        if (s.sign_pending) begin
            s.sign_pending = 1'b0;
            if (!dig) begin
                s.rejected = 1'b1;
                s.phase    = PH_DONE;
                return s;
            end
        end
        // any other character stops the scan without judging the line
        if (!(is_blank(c) || dig || comma || sgn)) begin
            s.phase = PH_DONE;
            return s;
        end
        if (sgn) begin
            if (!s.after_comma) begin
                s.rejected = 1'b1;
                s.phase    = PH_DONE;
                return s;
            end
            s.sign_pending = 1'b1;
        end
        // doubled comma
        if (comma && s.after_comma) begin
            s.rejected = 1'b1;
            s.phase    = PH_DONE;
            return s;
        end
        if (!s.after_comma && is_blank(c) && s.digit_seen) begin
            s.gap_seen = 1'b1;
        end
        if (dig) begin
            s.digit_seen  = 1'b1;
            s.after_comma = 1'b0;
            if (s.gap_seen || s.leading_zero) begin
                s.rejected = 1'b1;
                s.phase    = PH_DONE;
                return s;
            end
        end
        if (s.number_start && (c == CH_ZERO)) begin
            s.leading_zero = 1'b1;
            s.number_start = 1'b0;
        end
        if (s.number_start && dig) begin
            s.number_start = 1'b0;
        end
        if (comma) begin
            s.leading_zero = 1'b0;
            s.gap_seen     = 1'b0;
            s.number_start = 1'b1;
            s.after_comma  = 1'b1;
            if (!s.digit_seen) begin
                s.rejected = 1'b1;
                s.phase    = PH_DONE;
            end
        end
        return s;
    endfunction

    // Full per-character update across all phases
    function automatic t_line_state take_char(t_line_state s_in, logic [7:0] c);
        t_line_state s;
        logic        key_now;
        s       = s_in;
        key_now = 1'b0;
        case (s.phase)
            PH_LEAD: begin
                if (is_blank(c)) begin
                    s.lead_seen = 1'b1;
                end else if (!s.lead_seen) begin
                    s.rejected = 1'b1;
                    s.phase    = PH_DONE;
                end else begin
                    s.phase      = PH_KEY;
                    s.prefix_pos = 3'd0;
                    key_now      = 1'b1;
                end
            end
            PH_KEY: begin
                key_now = 1'b1;
            end
            PH_SEP: begin
                if (!is_blank(c)) begin
                    s.rejected = 1'b1;
                    s.phase    = PH_DONE;
                end else begin
                    s.phase = PH_SCAN;
                    s       = scan_char(s, c);
                end
            end
            PH_SCAN: begin
                s = scan_char(s, c);
            end
            default: begin
            end
        endcase
        // keyword match, also reached from the first non-blank character
        if (key_now) begin
            if ((s.prefix_pos >= KW_LEN) || (c != keyword_char(s.prefix_pos))) begin
                s.rejected = 1'b1;
                s.phase    = PH_DONE;
            end else begin
                s.prefix_pos = s.prefix_pos + 3'd1;
                if (s.prefix_pos == KW_LEN) begin
                    s.phase = PH_SEP;
                end
            end
        end
        return s;
    endfunction

    // Verdict on the state left by the final character
    function automatic logic verdict(t_line_state s);
        return !s.rejected && !s.sign_pending && s.digit_seen && !s.after_comma
            && ((s.phase == PH_SCAN) || (s.phase == PH_DONE));
    endfunction

endpackage

>>> hdl/data_directive_syntax_check.sv
// Data-directive syntax checker: one character per beat, one verdict per line.
// Depends on ddsc_pkg.
//
//   channel   dir  handshake                  payload
//   -------   ---  -------------------------  -----------------
//   input     in   i_in_valid / o_in_ready    i_ch[7:0], i_last
//   result    out  o_out_valid / i_out_ready  o_valid_res
//
// Throughput is one character per cycle unless a final character waits on a stalled
// result; the verdict, computed from the input register, is registered for output.
// Only the beat carrying i_last produces a result beat; the line state then returns
// to its reset value. Reset (i_rst_n low, synchronous) empties both registers.
// A stalled result only blocks the input register when it holds a final character.
module data_directive_syntax_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_valid_res
);

    logic                  r_in_vld;
    logic [7:0]            r_in_ch;
    logic                  r_in_last;
    ddsc_pkg::t_line_state r_st;
    ddsc_pkg::t_line_state n_st;
    logic                  r_out_vld;
    logic                  r_out_res;
    logic                  n_out_res;
    logic                  w_in_acc;
    logic                  w_adv;

    // Stage advance: non-final characters always move, a final one needs the slot
    assign w_adv      = r_in_vld && (!r_in_last || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // Per-character update and verdict
    always_comb begin
        n_st      = ddsc_pkg::take_char(r_st, r_in_ch);
        n_out_res = ddsc_pkg::verdict(n_st);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_st      <= ddsc_pkg::LINE_RST;
        end else begin
            if (w_in_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_st <= r_in_last ? ddsc_pkg::LINE_RST : n_st;
            end
            if (w_adv && r_in_last) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_ch   <= i_ch;
            r_in_last <= i_last;
        end
        if (w_adv && r_in_last) begin
            r_out_res <= n_out_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_valid_res = r_out_res;

endmodule

>>> hdl/ddsc_checker.sv
// Port-level checker for the data-directive syntax checker, bound to the top level.
// Depends on data_directive_syntax_check_assert.svh.
`include "data_directive_syntax_check_assert.svh"

module ddsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_last,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_valid_res
);

    logic w_last_acc;
    logic r_due_1;
    logic r_due_2;

    // Final character taken while the result slot was empty
    assign w_last_acc = i_in_valid && o_in_ready && i_last && !o_out_valid;

    // History of such beats in r_due_1 and r_due_2, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_due_1 <= 1'b0;
            r_due_2 <= 1'b0;
        end else begin
            r_due_1 <= w_last_acc;
            r_due_2 <= r_due_1;
        end
    end

    // Held result beat stays and keeps its verdict
    `DDSC_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `DDSC_ASSERT_NXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_valid_res))
    // A free result slot never blocks the input side
    `DDSC_ASSERT_IMP(a_in_free, !o_out_valid || i_out_ready, o_in_ready)
    // A final character taken into an empty slot has a result beat by the time it reaches r_due_2
    `DDSC_ASSERT_IMP(a_verdict_due, r_due_2, o_out_valid)

endmodule

bind data_directive_syntax_check ddsc_checker u_ddsc_checker (.*);

>>> tb/sv/tb.sv
// Self-checking testbench for data_directive_syntax_check: drives source-line characters
// and checks each end-of-line verdict against an in-bench line scanner.
// Depends on ddsc_pkg (phase codes, character constants) and the block itself.
`timescale 1ns / 100ps

module tb;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_CHARS = 780;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned MAX_REPORTS  = 10;

    localparam logic [7:0]  CH_SEMI  = 8'h3B;
    // ".data", first character in the top byte
    localparam logic [39:0] KW_BYTES = {ddsc_pkg::CH_DOT, ddsc_pkg::CH_LC_D,
                                        ddsc_pkg::CH_LC_A, ddsc_pkg::CH_LC_T,
                                        ddsc_pkg::CH_LC_A};

    typedef enum int {MUT_REPLACE, MUT_INSERT, MUT_DROP, MUT_CUT} t_line_damage;

    // Scanner state for the line in flight
    typedef struct {
        logic [2:0] phase;
        logic [2:0] kw_pos;
        bit         lead;
        bit         comma_open;
        bit         any_digit;
        bit         gap;
        bit         zero_first;
        bit         num_start;
        bit         sign_open;
        bit         bad;
    } t_scan_state;

    logic       i_clk       = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] in_ch       = 8'h00;
    logic       in_last     = 1'b0;
    logic       out_ready   = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic       valid_res;

    t_scan_state scan_st;
    logic [7:0]  line_buf[$];
    bit          verdict_q[$];
    int unsigned verdict_line_q[$];

    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int unsigned rx_gap_left  = 0;
    int unsigned rx_hold_req  = 0;
    int unsigned rx_hold_left = 0;

    int unsigned cycle_count      = 0;
    int unsigned fail_count       = 0;
    int unsigned lines_sent       = 0;
    int unsigned chars_sent       = 0;
    int unsigned verdicts_checked = 0;
    int unsigned verdicts_true    = 0;

    always #5 i_clk = ~i_clk;

    data_directive_syntax_check dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_ch        (in_ch),
        .i_last      (in_last),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_valid_res (valid_res)
    );

    // ---------------------------------------------------------------- line scanner

    function automatic bit blank_ch(logic [7:0] c);
        return (c == ddsc_pkg::CH_SPACE) || (c == ddsc_pkg::CH_TAB);
    endfunction

    function automatic bit digit_ch(logic [7:0] c);
        return (c >= ddsc_pkg::CH_ZERO) && (c <= ddsc_pkg::CH_NINE);
    endfunction

    function automatic void line_reset();
        scan_st = '{phase: ddsc_pkg::PH_LEAD, kw_pos: 3'd0, lead: 1'b0, comma_open: 1'b0,
                    any_digit: 1'b0, gap: 1'b0, zero_first: 1'b0, num_start: 1'b1,
                    sign_open: 1'b0, bad: 1'b0};
    endfunction

    function automatic void mark_bad();
        scan_st.bad   = 1'b1;
        scan_st.phase = ddsc_pkg::PH_DONE;
    endfunction

    function automatic void match_keyword(logic [7:0] c);
        if (scan_st.kw_pos >= ddsc_pkg::KW_LEN) begin
            mark_bad();
        end else if (c != KW_BYTES[39 - 8 * scan_st.kw_pos -: 8]) begin
            mark_bad();
        end else begin
            scan_st.kw_pos = scan_st.kw_pos + 3'd1;
            if (scan_st.kw_pos == ddsc_pkg::KW_LEN) scan_st.phase = ddsc_pkg::PH_SEP;
        end
    endfunction

    // Number-list rules, in the order they take effect
    function automatic void list_step(logic [7:0] c);
        bit dig;
        bit sgn;
        bit com;
        dig = digit_ch(c);
        sgn = (c == ddsc_pkg::CH_PLUS) || (c == ddsc_pkg::CH_MINUS);
        com = (c == ddsc_pkg::CH_COMMA);
        if (scan_st.sign_open) begin
            scan_st.sign_open = 1'b0;
            if (!dig) begin
                mark_bad();
                return;
            end
        end
        // anything outside the list alphabet ends the scan, no judgement
        if (!(blank_ch(c) || dig || com || sgn)) begin
            scan_st.phase = ddsc_pkg::PH_DONE;
            return;
        end
        if (sgn) begin
            if (!scan_st.comma_open) begin
                mark_bad();
                return;
            end
            scan_st.sign_open = 1'b1;
        end
        if (com && scan_st.comma_open) begin
            mark_bad();
            return;
        end
        if (!scan_st.comma_open && blank_ch(c) && scan_st.any_digit) scan_st.gap = 1'b1;
        if (dig) begin
            scan_st.any_digit  = 1'b1;
            scan_st.comma_open = 1'b0;
            if (scan_st.gap || scan_st.zero_first) begin
                mark_bad();
                return;
            end
        end
        if (scan_st.num_start && (c == ddsc_pkg::CH_ZERO)) begin
            scan_st.zero_first = 1'b1;
            scan_st.num_start  = 1'b0;
        end
        if (scan_st.num_start && dig) scan_st.num_start = 1'b0;
        if (com) begin
            scan_st.zero_first = 1'b0;
            scan_st.gap        = 1'b0;
            scan_st.num_start  = 1'b1;
            scan_st.comma_open = 1'b1;
            if (!scan_st.any_digit) mark_bad();
        end
    endfunction

    function automatic void absorb_char(logic [7:0] c);
        case (scan_st.phase)
            ddsc_pkg::PH_LEAD: begin
                if (blank_ch(c)) begin
                    scan_st.lead = 1'b1;
                end else if (!scan_st.lead) begin
                    mark_bad();
                end else begin
                    // first non-blank is also the first keyword character
                    scan_st.phase  = ddsc_pkg::PH_KEY;
                    scan_st.kw_pos = 3'd0;
                    match_keyword(c);
                end
            end
            ddsc_pkg::PH_KEY: match_keyword(c);
            ddsc_pkg::PH_SEP: begin
                if (!blank_ch(c)) begin
                    mark_bad();
                end else begin
                    scan_st.phase = ddsc_pkg::PH_SCAN;
                    list_step(c);
                end
            end
            ddsc_pkg::PH_SCAN: list_step(c);
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int unsigned draw_gap(bit idle_on);
        return idle_on ? $urandom_range(0, 9) : 0;
    endfunction

    function automatic logic [7:0] blank_pick();
        return $urandom_range(0, 1) ? ddsc_pkg::CH_SPACE : ddsc_pkg::CH_TAB;
    endfunction

    function automatic logic [7:0] digit_pick(int unsigned lo);
        return 8'(ddsc_pkg::CH_ZERO + $urandom_range(lo, 9));
    endfunction

    // characters that sit on the rule boundaries
    function automatic logic [7:0] tricky_char();
        case ($urandom_range(0, 7))
            0:       return ddsc_pkg::CH_SPACE;
            1:       return ddsc_pkg::CH_TAB;
            2:       return ddsc_pkg::CH_COMMA;
            3:       return ddsc_pkg::CH_PLUS;
            4:       return ddsc_pkg::CH_MINUS;
            5:       return ddsc_pkg::CH_ZERO;
            6:       return digit_pick(1);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    // Mostly well-formed declarations, some damaged, some plain noise
    function automatic void make_line();
        int           kind;
        int           cnt;
        int           nd;
        int           pos;
        t_line_damage dmg;
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(1, 3)) line_buf.push_back(blank_pick());
        for (int k = 0; k < ddsc_pkg::KW_LEN; k++) line_buf.push_back(KW_BYTES[39 - 8 * k -: 8]);
        line_buf.push_back(blank_pick());
        cnt = $urandom_range(1, 4);
        for (int n = 0; n < cnt; n++) begin
            if (n != 0) begin
                if ($urandom_range(0, 3) == 0) line_buf.push_back(blank_pick());
                line_buf.push_back(ddsc_pkg::CH_COMMA);
                if ($urandom_range(0, 3) == 0) line_buf.push_back(blank_pick());
                if ($urandom_range(0, 3) == 0)
                    line_buf.push_back($urandom_range(0, 1) ? ddsc_pkg::CH_PLUS
                                                            : ddsc_pkg::CH_MINUS);
            end
            if ($urandom_range(0, 4) == 0) begin
                line_buf.push_back(ddsc_pkg::CH_ZERO);
            end else begin
                nd = $urandom_range(1, 3);
                line_buf.push_back(digit_pick(1));
                for (int d = 1; d < nd; d++) line_buf.push_back(digit_pick(0));
            end
        end
        if ($urandom_range(0, 5) == 0) line_buf.push_back(blank_pick());
        // short comment tail, ignored by the scan
        if ($urandom_range(0, 7) == 0) begin
            line_buf.push_back(CH_SEMI);
            repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (kind >= 70) begin
            repeat ($urandom_range(1, 2)) begin
                pos = $urandom_range(0, line_buf.size() - 1);
                dmg = t_line_damage'($urandom_range(0, 3));
                case (dmg)
                    MUT_REPLACE: line_buf[pos] = tricky_char();
                    MUT_INSERT:  line_buf.insert(pos, tricky_char());
                    MUT_DROP:    if (line_buf.size() > 1) line_buf.delete(pos);
                    default:     while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
                endcase
            end
        end
    endfunction

    // ---------------------------------------------------------------- sender

    // One input beat; valid stays high afterwards unless the next beat waits
    task automatic send_char(input logic [7:0] c, input logic l);
        int unsigned gap;
        gap = draw_gap(tx_idle);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_ch    <= c;
        in_last  <= l;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        chars_sent++;
        absorb_char(c);
        if (l) begin
            verdict_q.push_back(!scan_st.bad && !scan_st.sign_open && scan_st.any_digit
                                && !scan_st.comma_open
                                && ((scan_st.phase == ddsc_pkg::PH_SCAN)
                                    || (scan_st.phase == ddsc_pkg::PH_DONE)));
            verdict_line_q.push_back(lines_sent);
            lines_sent++;
            line_reset();
        end
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++) send_char(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic send_text(string s);
        line_buf.delete();
        put_text(s);
        send_line();
    endtask

    // ---------------------------------------------------------------- result side

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic void check_verdict(logic got);
        bit          exp;
        int unsigned idx;
        if (verdict_q.size() == 0) begin
            note_failure($sformatf("verdict %0b with no line outstanding", got));
        end else begin
            exp = verdict_q.pop_front();
            idx = verdict_line_q.pop_front();
            verdicts_checked++;
            if (exp) verdicts_true++;
            if (got !== exp)
                note_failure($sformatf("line %0d verdict expected %0b actual %0b", idx, exp, got));
        end
    endfunction

    // Result beats: check, then draw the ready pattern (gaps and long hold-off)
    always @(posedge i_clk) begin : result_side
        bit take;
        take = out_ready && out_valid;
        if (take && rst_n) check_verdict(valid_res);
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (take) rx_gap_left = draw_gap(rx_idle);
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end else if (rx_gap_left != 0) begin
            rx_gap_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Run time guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("cycle limit hit, %0d verdicts outstanding", verdict_q.size());
            $display("** data_directive_syntax_check: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // Every rule and boundary once, by hand
    task automatic test_directed();
        send_text(" .data 1");
        send_text("\t.data\t5,+7,-3");
        send_text("  .data 99, 0 ,7 ");
        send_text(" .data 0");
        send_text(".data 1");          // no leading blank
        send_text("  .dat 1");         // wrong keyword
        send_text(" .data1");          // no blank after keyword
        send_text(" .data 1,,2");      // doubled comma
        send_text(" .data ,1");        // comma before any digit
        send_text(" .data 1,");        // trailing comma
        send_text(" .data 1 2");       // gap between digits
        send_text(" .data 05");        // digit after leading zero
        send_text(" .data +1");        // sign on the first number
        send_text(" .data 1,+");       // line ends on a sign
        send_text(" .data 1,- 2");     // sign not followed by a digit
        send_text(" .data ");          // empty list
        send_text(" .d");              // ends before the list
        send_text(" .data 12;x,,");    // foreign character stops the scan
        // NUL and top byte inside the list, then as lone characters
        line_buf.delete();
        put_text(" .data 3");
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        send_line();
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(ddsc_pkg::CH_SPACE, 1'b1);
    endtask

    // Random lines, with stretches of idling switched off on either side
    task automatic test_random_lines();
        int unsigned start;
        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS) begin
            if ($urandom_range(0, 11) == 0) tx_idle = !tx_idle;
            if ($urandom_range(0, 11) == 0) rx_idle = !rx_idle;
            make_line();
            send_line();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Hold the result side off while lines keep arriving back to back
    task automatic test_result_backpressure();
        tx_idle     = 1'b0;
        rx_hold_req = 400;
        for (int n = 0; n < 40; n++) begin
            if (n % 3 == 0) send_text(" .data 7");
            else send_text("7");
        end
        tx_idle = 1'b1;
    endtask

    initial begin
        line_reset();
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_lines();
        test_result_backpressure();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d line verdicts (%0d valid) over %0d characters, %0d cycles",
                 verdicts_checked, verdicts_true, chars_sent, cycle_count);
        $display("includes hand-written rule cases, random damaged lines and a long result stall");
        if ((fail_count == 0) && (verdict_q.size() == 0)) begin
            $display("** data_directive_syntax_check: PASSED **");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("** data_directive_syntax_check: FAILED **");
        end
        $finish;
    end

endmodule
